>>> rtl/core/mcne_pkg.sv
package mcne_pkg;

    localparam int DIMENSIONS = 3;
    localparam int MAX_LEVEL  = 10;
    localparam int NUM_AXES   = 3;
    localparam int IDX_W      = 30;
    localparam int LVL_W      = 4;
    localparam int COORD_W    = MAX_LEVEL;
    localparam int CNT_W      = 2;
    localparam int SHIFT_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [SHIFT_W-1:0] SHIFT_ZERO = 2'b00;
    localparam logic [SHIFT_W-1:0] SHIFT_POS  = 2'b01;
    localparam logic [SHIFT_W-1:0] SHIFT_NEG  = 2'b11;

    localparam logic BOUNDARY_OPEN     = 1'b0;
    localparam logic BOUNDARY_PERIODIC = 1'b1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    typedef struct packed {
        idx_t [2:0]   spread;
        shift_t [2:0] shift;
        cnt_t         cnt;
    } axis_desc_t;

    typedef struct packed {
        axis_desc_t [NUM_AXES-1:0] axis;
    } item_desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic coord_t axis_coord(idx_t ci, int axis);
        coord_t pos;
        pos = '0;
        for (int b = 0; b < COORD_W; b++)
        begin
            if (DIMENSIONS * b + axis < IDX_W)
            begin
                pos[b] = ci[DIMENSIONS * b + axis];
            end
        end
        return pos;
    endfunction

    function automatic idx_t axis_spread(coord_t pos, int axis);
        idx_t v;
        v = '0;
        for (int b = 0; b < COORD_W; b++)
        begin
            if (DIMENSIONS * b + axis < IDX_W)
            begin
                v[DIMENSIONS * b + axis] = pos[b];
            end
        end
        return v;
    endfunction

endpackage

>>> rtl/core/morton_cell_neighbour_enumerator.sv
// An item accepted into an idle block passes the item queue and cur_reg before its first result is registered.
// One result per cycle while out_ready does not stall the output register; an item yields
// 27 results in periodic mode and 8 to 27 in open mode.
// Input and result sides run decoupled through a two-entry item queue.
// Reset: rst_n clears the queue, sequencer and output valid; boundary_mode resets to periodic.
module morton_cell_neighbour_enumerator
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [29:0]                cell_key,
    input  logic [3:0]                 level,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [29:0]                neighbour_index,
    output logic signed [1:0]          shift_axis0,
    output logic signed [1:0]          shift_axis1,
    output logic signed [1:0]          shift_axis2,
    output logic                       last
);

    mcne_pkg::q_status_t  q_status;
    mcne_pkg::item_desc_t push_desc;
    mcne_pkg::item_desc_t pop_desc;
    logic                 push;
    logic                 pop;
    mcne_pkg::shift_t     sh0;
    mcne_pkg::shift_t     sh1;
    mcne_pkg::shift_t     sh2;

    mcne_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_key  (cell_key),
        .level     (level),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    mcne_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_desc(push_desc),
        .pop      (pop),
        .pop_desc (pop_desc),
        .q_status (q_status)
    );

    mcne_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .pop_desc       (pop_desc),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .neighbour_index(neighbour_index),
        .shift_axis0    (sh0),
        .shift_axis1    (sh1),
        .shift_axis2    (sh2),
        .last           (last)
    );

    assign shift_axis0 = $signed(sh0);
    assign shift_axis1 = $signed(sh1);
    assign shift_axis2 = $signed(sh2);

endmodule

>>> rtl/core/mcne_front.sv
module mcne_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mcne_pkg::idx_t         cell_key,
    input  logic [mcne_pkg::LVL_W-1:0] level,
    input  mcne_pkg::q_status_t    q_status,
    output logic                   push,
    output mcne_pkg::item_desc_t   push_desc
);

    logic                         boundary_mode_reg;
    logic [mcne_pkg::LVL_W-1:0]   lev_sat;
    mcne_pkg::coord_t             top;
    mcne_pkg::coord_t             coord_all_ones;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_mode_reg <= mcne_pkg::BOUNDARY_PERIODIC;
        end
        else if (cfg_we)
        begin
            boundary_mode_reg <= cfg_wdata;
        end
    end

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;
    assign coord_all_ones = '1;

    always_comb
    begin
        if (level == '0)
        begin
            lev_sat = mcne_pkg::LVL_W'(1);
        end
        else if (32'(level) > mcne_pkg::MAX_LEVEL)
        begin
            lev_sat = mcne_pkg::LVL_W'(mcne_pkg::MAX_LEVEL);
        end
        else
        begin
            lev_sat = level;
        end
        top = ~(coord_all_ones << lev_sat);
    end

    always_comb
    begin
        mcne_pkg::coord_t p;
        mcne_pkg::coord_t pm;
        mcne_pkg::coord_t pp;
        push_desc = '0;
        for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
        begin
            p  = mcne_pkg::axis_coord(cell_key, a) & top;
            pm = p - mcne_pkg::COORD_W'(1);
            pp = p + mcne_pkg::COORD_W'(1);
            push_desc.axis[a].shift = {3{mcne_pkg::SHIFT_ZERO}};
            if (a >= mcne_pkg::DIMENSIONS)
            begin
                push_desc.axis[a].cnt = mcne_pkg::CNT_W'(1);
            end
            else if (boundary_mode_reg == mcne_pkg::BOUNDARY_PERIODIC)
            begin
                push_desc.axis[a].spread[0] = mcne_pkg::axis_spread(pm & top, a);
                push_desc.axis[a].spread[1] = mcne_pkg::axis_spread(p, a);
                push_desc.axis[a].spread[2] = mcne_pkg::axis_spread(pp & top, a);
                push_desc.axis[a].shift[0]  = (p == '0) ? mcne_pkg::SHIFT_NEG
                                                        : mcne_pkg::SHIFT_ZERO;
                push_desc.axis[a].shift[2]  = (p == top) ? mcne_pkg::SHIFT_POS
                                                         : mcne_pkg::SHIFT_ZERO;
                push_desc.axis[a].cnt       = mcne_pkg::CNT_W'(3);
            end
            else if (p == '0)
            begin
                push_desc.axis[a].spread[0] = '0;
                push_desc.axis[a].spread[1] = mcne_pkg::axis_spread(mcne_pkg::COORD_W'(1), a);
                push_desc.axis[a].cnt       = mcne_pkg::CNT_W'(2);
            end
            else if (p == top)
            begin
                push_desc.axis[a].spread[0] = mcne_pkg::axis_spread(p, a);
                push_desc.axis[a].spread[1] = mcne_pkg::axis_spread(pm, a);
                push_desc.axis[a].cnt       = mcne_pkg::CNT_W'(2);
            end
            else
            begin
                push_desc.axis[a].spread[0] = mcne_pkg::axis_spread(pm, a);
                push_desc.axis[a].spread[1] = mcne_pkg::axis_spread(p, a);
                push_desc.axis[a].spread[2] = mcne_pkg::axis_spread(pp, a);
                push_desc.axis[a].cnt       = mcne_pkg::CNT_W'(3);
            end
        end
    end

endmodule

>>> rtl/core/mcne_queue.sv
module mcne_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mcne_pkg::item_desc_t push_desc,
    input  logic                 pop,
    output mcne_pkg::item_desc_t pop_desc,
    output mcne_pkg::q_status_t  q_status
);

    mcne_pkg::item_desc_t mem [mcne_pkg::QUEUE_DEPTH];
    logic [mcne_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mcne_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mcne_pkg::QUEUE_PTR_W:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == (mcne_pkg::QUEUE_PTR_W+1)'(mcne_pkg::QUEUE_DEPTH));
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_desc = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == mcne_pkg::QUEUE_DEPTH - 1) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == mcne_pkg::QUEUE_DEPTH - 1) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/core/mcne_back.sv
module mcne_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcne_pkg::q_status_t  q_status,
    input  mcne_pkg::item_desc_t pop_desc,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mcne_pkg::idx_t       neighbour_index,
    output mcne_pkg::shift_t     shift_axis0,
    output mcne_pkg::shift_t     shift_axis1,
    output mcne_pkg::shift_t     shift_axis2,
    output logic                 last
);

    logic                 busy_reg, busy_next;
    mcne_pkg::item_desc_t cur_reg, cur_next;
    mcne_pkg::cnt_t       j_reg  [mcne_pkg::NUM_AXES];
    mcne_pkg::cnt_t       j_next [mcne_pkg::NUM_AXES];
    logic                 out_valid_reg, out_valid_next;
    mcne_pkg::idx_t       index_reg;
    mcne_pkg::shift_t     shift_reg [mcne_pkg::NUM_AXES];
    logic                 last_reg;

    logic [mcne_pkg::NUM_AXES-1:0] at_max;
    logic                 res_last;
    mcne_pkg::idx_t       res_index;
    mcne_pkg::shift_t     res_shift [mcne_pkg::NUM_AXES];
    logic                 out_free;
    logic                 emit;

    always_comb
    begin
        res_index = '0;
        for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
        begin
            at_max[a]    = (j_reg[a] == cur_reg.axis[a].cnt - 1'b1);
            res_index    = res_index | cur_reg.axis[a].spread[j_reg[a]];
            res_shift[a] = cur_reg.axis[a].shift[j_reg[a]];
        end
        res_last = &at_max;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    assign pop      = !q_status.empty && (!busy_reg || (emit && res_last));

    always_comb
    begin
        logic carry;
        busy_next = busy_reg;
        cur_next  = cur_reg;
        carry     = 1'b1;
        for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
        begin
            j_next[a] = j_reg[a];
        end
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = pop_desc;
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                j_next[a] = '0;
            end
        end
        else if (emit && res_last)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                if (carry)
                begin
                    if (at_max[a])
                    begin
                        j_next[a] = '0;
                    end
                    else
                    begin
                        j_next[a] = j_reg[a] + 1'b1;
                        carry     = 1'b0;
                    end
                end
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                j_reg[a] <= '0;
            end
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                j_reg[a] <= j_next[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            index_reg <= res_index;
            last_reg  <= res_last;
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                shift_reg[a] <= res_shift[a];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign neighbour_index = index_reg;
    assign shift_axis0     = shift_reg[0];
    assign shift_axis1     = shift_reg[1];
    assign shift_axis2     = shift_reg[2];
    assign last            = last_reg;

endmodule

>>> tb/sv/tb_morton_cell_neighbour_enumerator.sv
`timescale 1ns / 1ps

module tb_morton_cell_neighbour_enumerator;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int HALF_PHASE_ITEMS = 24;
    localparam logic [RANDOM_PHASES-1:0] MODE_PLAN = 6'b101001;
    localparam mcne_pkg::idx_t IDX_ALL = '1;

    typedef struct packed {
        mcne_pkg::idx_t         idx;
        mcne_pkg::shift_t [2:0] sh;
        logic                   last;
    } neighbour_t;

    typedef struct packed {
        mcne_pkg::idx_t ci;
        logic [3:0]     lv;
    } cell_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [29:0] cell_key = '0;
    logic [3:0]  level = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [29:0] neighbour_index;
    logic signed [1:0] shift_axis0;
    logic signed [1:0] shift_axis1;
    logic signed [1:0] shift_axis2;
    logic        last;

    cell_req_t  cell_queue[$];
    neighbour_t neighbour_queue[$];
    cell_req_t  next_req;
    logic       periodic_now = mcne_pkg::BOUNDARY_PERIODIC;

    int errors = 0;
    int cycles = 0;
    int n_cells = 0;
    int n_results = 0;
    int n_open_cells = 0;
    int n_mode_writes = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rdy_tick = 0;
    int rdy_mode = 0;

    morton_cell_neighbour_enumerator dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cell_key        (cell_key),
        .level           (level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .neighbour_index (neighbour_index),
        .shift_axis0     (shift_axis0),
        .shift_axis1     (shift_axis1),
        .shift_axis2     (shift_axis2),
        .last            (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic mcne_pkg::coord_t gather_axis(mcne_pkg::idx_t ci, int axis, int lev);
        mcne_pkg::coord_t p;
        p = '0;
        for (int b = 0; b < lev; b++)
        begin
            p[b] = ci[mcne_pkg::DIMENSIONS * b + axis];
        end
        return p;
    endfunction

    function automatic mcne_pkg::idx_t scatter_axis(mcne_pkg::coord_t p, int axis, int lev);
        mcne_pkg::idx_t v;
        v = '0;
        for (int b = 0; b < lev; b++)
        begin
            v[mcne_pkg::DIMENSIONS * b + axis] = p[b];
        end
        return v;
    endfunction

    function automatic int clamp_level(logic [3:0] lv);
        int lev;
        lev = lv;
        if (lev < 1)
        begin
            lev = 1;
        end
        if (lev > mcne_pkg::MAX_LEVEL)
        begin
            lev = mcne_pkg::MAX_LEVEL;
        end
        return lev;
    endfunction

    function automatic void predict_neighbours(mcne_pkg::idx_t ci, logic [3:0] lv, logic mode);
        int lev;
        int total;
        int rem;
        int j;
        int cnt[3];
        mcne_pkg::coord_t top;
        mcne_pkg::coord_t p;
        mcne_pkg::coord_t pos[3][3];
        mcne_pkg::shift_t sh[3][3];
        neighbour_t r;
        lev = clamp_level(lv);
        top = mcne_pkg::coord_t'((1 << lev) - 1);
        total = 1;
        for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
        begin
            p = gather_axis(ci, a, lev);
            for (int k = 0; k < 3; k++)
            begin
                sh[a][k] = mcne_pkg::SHIFT_ZERO;
                pos[a][k] = '0;
            end
            if (mode == mcne_pkg::BOUNDARY_PERIODIC)
            begin
                pos[a][0] = (p - 1'b1) & top;
                pos[a][1] = p;
                pos[a][2] = (p + 1'b1) & top;
                if (p == '0)
                begin
                    sh[a][0] = mcne_pkg::SHIFT_NEG;
                end
                if (p == top)
                begin
                    sh[a][2] = mcne_pkg::SHIFT_POS;
                end
                cnt[a] = 3;
            end
            else if (p == '0)
            begin
                pos[a][0] = '0;
                pos[a][1] = mcne_pkg::coord_t'(1);
                cnt[a] = 2;
            end
            else if (p == top)
            begin
                pos[a][0] = p;
                pos[a][1] = p - 1'b1;
                cnt[a] = 2;
            end
            else
            begin
                pos[a][0] = p - 1'b1;
                pos[a][1] = p;
                pos[a][2] = p + 1'b1;
                cnt[a] = 3;
            end
            total *= cnt[a];
        end
        for (int k = 0; k < total; k++)
        begin
            rem = k;
            r = '0;
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                j = rem % cnt[a];
                rem = rem / cnt[a];
                r.idx |= scatter_axis(pos[a][j], a, lev);
                r.sh[a] = sh[a][j];
            end
            r.last = (k == total - 1);
            neighbour_queue.insert(neighbour_queue.size(), r);
        end
    endfunction

    function automatic mcne_pkg::idx_t make_cell(int c0, int c1, int c2, int lev);
        return scatter_axis(mcne_pkg::coord_t'(c0), 0, lev)
            | scatter_axis(mcne_pkg::coord_t'(c1), 1, lev)
            | scatter_axis(mcne_pkg::coord_t'(c2), 2, lev);
    endfunction

    task automatic push_cell(mcne_pkg::idx_t ci, logic [3:0] lv);
        cell_req_t req;
        req.ci = ci;
        req.lv = lv;
        cell_queue.insert(cell_queue.size(), req);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (cell_queue.size() != 0 || in_valid || neighbour_queue.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_mode(logic mode);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        periodic_now = mode;
        n_mode_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_directed();
        push_cell('0, 4'd1);
        push_cell(IDX_ALL, 4'd1);
        push_cell('0, 4'd10);
        push_cell(IDX_ALL, 4'd10);
        push_cell('0, 4'd0);
        push_cell(IDX_ALL, 4'd15);
        push_cell(make_cell(0, 1023, 512, 10), 4'd10);
        push_cell(make_cell(5, 0, 7, 3) | 30'h3FFFFE00, 4'd3);
        push_cell(make_cell(1, 2, 6, 3), 4'd3);
        push_cell(make_cell(1, 0, 1, 1), 4'd1);
        push_cell(30'h15555555, 4'd12);
        push_cell(make_cell(7, 15, 0, 4), 4'd4);
    endtask

    task automatic push_random();
        logic [3:0] lv;
        int lev;
        int top;
        int c;
        mcne_pkg::idx_t ci;
        mcne_pkg::idx_t hi;
        case ($urandom_range(0, 19))
            0: lv = 4'd0;
            1: lv = 4'($urandom_range(11, 15));
            default: lv = 4'($urandom_range(1, 10));
        endcase
        lev = clamp_level(lv);
        top = (1 << lev) - 1;
        if ($urandom_range(0, 7) == 0)
        begin
            ci = mcne_pkg::idx_t'($urandom);
        end
        else
        begin
            ci = '0;
            for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
            begin
                case ($urandom_range(0, 4))
                    0: c = 0;
                    1: c = top;
                    2: c = 1;
                    3: c = top - 1;
                    default: c = $urandom & top;
                endcase
                ci |= scatter_axis(mcne_pkg::coord_t'(c), a, lev);
            end
            hi = IDX_ALL << (mcne_pkg::DIMENSIONS * lev);
            if ($urandom_range(0, 1) == 1)
            begin
                ci |= mcne_pkg::idx_t'($urandom) & hi;
            end
        end
        push_cell(ci, lv);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_neighbours(cell_key, level, periodic_now);
                n_cells++;
                if (periodic_now != mcne_pkg::BOUNDARY_PERIODIC)
                begin
                    n_open_cells++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cell_queue.size() != 0)
                begin
                    next_req = cell_queue.pop_front();
                    in_valid <= 1'b1;
                    cell_key <= next_req.ci;
                    level <= next_req.lv;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        neighbour_t want;
        mcne_pkg::shift_t [2:0] got_sh;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                got_sh = {shift_axis2, shift_axis1, shift_axis0};
                if (neighbour_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result expected none got idx %h last %b",
                        $time, neighbour_index, last);
                end
                else
                begin
                    want = neighbour_queue.pop_front();
                    if (neighbour_index !== want.idx)
                    begin
                        errors++;
                        $display("%0t: neighbour_index expected %h got %h",
                            $time, want.idx, neighbour_index);
                    end
                    for (int a = 0; a < mcne_pkg::NUM_AXES; a++)
                    begin
                        if (got_sh[a] !== want.sh[a])
                        begin
                            errors++;
                            $display("%0t: shift_axis%0d expected %0d got %0d", $time, a,
                                $signed(want.sh[a]), $signed(got_sh[a]));
                        end
                    end
                    if (last !== want.last)
                    begin
                        errors++;
                        $display("%0t: last expected %b got %b", $time, want.last, last);
                    end
                end
            end
            rdy_tick++;
            if (rdy_tick % 64 == 0)
            begin
                rdy_mode = $urandom_range(0, 3);
            end
            case (rdy_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (rdy_tick % 8) < 3;
                default: out_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_directed();
        wait_drained();
        write_mode(mcne_pkg::BOUNDARY_OPEN);
        push_directed();
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_mode(MODE_PLAN[ph]);
            repeat (HALF_PHASE_ITEMS) push_random();
            wait_drained();
            repeat (HALF_PHASE_ITEMS) push_random();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d cells (%0d open, %0d periodic), %0d neighbour results",
            n_cells, n_open_cells, n_cells - n_open_cells, n_results);
        $display("boundary mode written %0d times, %0d check failures", n_mode_writes, errors);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
